@@ hw/rtl/xcpd_pkg.sv @@
// Package for the XOR-checked packet deframer.
// Holds frame layout constants, reset values and the sequencer state type.
// Used by the store, the controller and the top level.
package xcpd_pkg;

  localparam int unsigned DEF_STORE_DEPTH = 64;
  localparam logic [7:0]  START_RESET     = 8'hAA;
  localparam int unsigned FRAME_OVERHEAD  = 4;
  localparam int unsigned POS_TYPE        = 1;
  localparam int unsigned POS_LEN         = 2;
  localparam int unsigned POS_DATA        = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_t;

endpackage

@@ hw/rtl/xcpd_in_if.sv @@
// Input channel of the deframer: one received byte per transfer.
// Carries valid, ready and the byte; no dependencies.
interface xcpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/xcpd_out_if.sv @@
// Result channel of the deframer: one payload item per transfer.
// Carries valid, ready and the result fields; no dependencies.
interface xcpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_type;
  logic [5:0] payload_length;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       last;
  logic       checksum_ok;

  modport source (output valid, output pkt_type, output payload_length,
                  output payload_byte, output byte_valid, output last,
                  output checksum_ok, input ready);
  modport sink (input valid, input pkt_type, input payload_length,
                input payload_byte, input byte_valid, input last,
                input checksum_ok, output ready);
endinterface

@@ hw/rtl/xcpd_store.sv @@
// Packet store: single write port, single read port with registered data.
// Depends on xcpd_pkg for the default depth.
module xcpd_store
  import xcpd_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  localparam int ADDR_W = $clog2(STORE_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/xcpd_ctrl.sv @@
// Frame tracker and readout sequencer of the deframer.
// Depends on xcpd_pkg, xcpd_in_if and xcpd_out_if; drives the packet store.
module xcpd_ctrl
  import xcpd_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  localparam int ADDR_W = $clog2(STORE_DEPTH),
  localparam int CNT_W = $clog2(STORE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  xcpd_in_if.sink           in_ch,
  xcpd_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data
);

  localparam int CMP_W = 9;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [7:0]        start_r;
  logic [7:0]        type_r, type_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        acc_r, acc_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              ok_r, ok_nxt;
  logic              bv_r, bv_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  pos_inc;
  logic              complete;
  logic [7:0]        idx_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      start_r <= START_RESET;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (cfg_we) begin
        start_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    len_r  <= len_nxt;
    acc_r  <= acc_nxt;
    idx_r  <= idx_nxt;
    ok_r   <= ok_nxt;
    bv_r   <= bv_nxt;
    last_r <= last_nxt;
  end

  // A start byte always lands at position zero.
  assign pos      = (in_ch.rx_byte == start_r) ? '0 : fill_r;
  assign pos_inc  = pos + CNT_W'(1);
  assign complete = ({1'b0, len_r} + CMP_W'(FRAME_OVERHEAD)) == CMP_W'(pos_inc);
  assign idx_inc  = 8'(idx_r) + 8'd1;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    ok_nxt    = ok_r;
    bv_nxt    = bv_r;
    last_nxt  = last_r;
    wr_en     = 1'b0;
    wr_addr   = pos[ADDR_W-1:0];
    wr_data   = in_ch.rx_byte;
    rd_en     = 1'b0;
    rd_addr   = ADDR_W'(POS_DATA) + idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && (pos < CNT_W'(STORE_DEPTH))) begin
          wr_en    = 1'b1;
          fill_nxt = pos_inc;
          if (pos == CNT_W'(POS_TYPE)) begin
            type_nxt = in_ch.rx_byte;
          end
          if (pos == CNT_W'(POS_LEN)) begin
            len_nxt = in_ch.rx_byte;
          end
          acc_nxt = (pos == '0) ? 8'd0 : (acc_r ^ in_ch.rx_byte);
          if (complete) begin
            // The byte that completes the frame is the checksum itself.
            ok_nxt  = (acc_r == in_ch.rx_byte);
            idx_nxt = '0;
            if (len_r == 8'd0) begin
              bv_nxt    = 1'b0;
              last_nxt  = 1'b1;
              state_nxt = ST_SHOW;
            end else begin
              bv_nxt    = 1'b1;
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        last_nxt  = (idx_inc == len_r);
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ch.ready) begin
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = (state_r == ST_SHOW);
  assign out_ch.pkt_type       = type_r;
  assign out_ch.payload_length = len_r[5:0];
  assign out_ch.payload_byte   = bv_r ? rd_data : 8'd0;
  assign out_ch.byte_valid     = bv_r;
  assign out_ch.last           = last_r;
  assign out_ch.checksum_ok    = ok_r;

endmodule

@@ hw/rtl/xor_checked_packet_deframer.sv @@
// Deframer for start-byte framed packets with an XOR checksum.
// Readout: the first result is shown in the cycle after the completing byte for
// an empty packet and after a store read (ST_READ) otherwise; each payload byte
// then passes through the store read and the output register and any output stall.
// Throughput: one input byte per cycle while no run is being read out.
// Reset clears the fill count, sets the start value to 0xAA; store is not cleared.
module xor_checked_packet_deframer
  import xcpd_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  xcpd_in_if.sink    in_ch,
  xcpd_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  xcpd_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  xcpd_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

@@ hw/rtl/xcpd_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
// Depends only on the top level's ports.
module xcpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pkt_type,
  input logic [5:0] out_payload_length,
  input logic [7:0] out_payload_byte,
  input logic       out_byte_valid,
  input logic       out_last,
  input logic       out_checksum_ok
);

  // Input is held off while a result is shown.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is shown");

  // A run ends with its last transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result still shown after the last transfer");

  // An empty packet gives a single item with no data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |->
      (out_last && (out_payload_length == 6'd0) && (out_payload_byte == 8'd0)))
    else $error("malformed empty packet item");

  // A stalled result holds its fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_pkt_type) && $stable(out_payload_length) &&
       $stable(out_payload_byte) && $stable(out_byte_valid) &&
       $stable(out_last) && $stable(out_checksum_ok)))
    else $error("stalled result changed");

endmodule

bind xor_checked_packet_deframer xcpd_checker u_xcpd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_pkt_type       (out_ch.pkt_type),
  .out_payload_length (out_ch.payload_length),
  .out_payload_byte   (out_ch.payload_byte),
  .out_byte_valid     (out_ch.byte_valid),
  .out_last           (out_ch.last),
  .out_checksum_ok    (out_ch.checksum_ok)
);
